// ===== hw/rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to hue and chroma core
// Field widths, hue constants and the records that travel between stages.
// ----------------------------------------------------------------------------
package rhc_pkg;

	// Payload widths
	localparam int PIXEL_W  = 32;
	localparam int HUE_W    = 15;
	localparam int CHROMA_W = 13;
	localparam int CHAN_W   = 8;

	// Hue constants in 1/64 degree units
	localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;
	localparam logic [HUE_W-1:0] HUE_SIXTH = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;

	// The quotient of 3840*num/den never exceeds 3840, so twelve bits suffice.
	// Each divider cell resolves one quotient bit.
	localparam int QUOT_W    = 12;
	localparam int NUM_CELLS = QUOT_W;

	// Values carried alongside the division
	typedef struct packed {
		logic [CHAN_W-1:0]   den;
		logic [HUE_W-1:0]    base;
		logic                neg;
		logic                grey;
		logic [CHROMA_W-1:0] chroma;
	} rhc_side_t;

	// State of one item while it passes the divider chain
	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [QUOT_W-1:0] low;
		logic [QUOT_W-1:0] quot;
		rhc_side_t         side;
	} rhc_div_t;

endpackage

// ===== hw/rtl/rhc_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rhc_pixel_if: pixel channel
// Valid/ready channel carrying one ARGB pixel per item.
// ----------------------------------------------------------------------------
interface rhc_pixel_if;
	import rhc_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);

endinterface

// ===== hw/rtl/rhc_result_if.sv =====
// ----------------------------------------------------------------------------
// rhc_result_if: result channel
// Valid/ready channel carrying hue, chroma and turned hue per item.
// ----------------------------------------------------------------------------
interface rhc_result_if;
	import rhc_pkg::*;

	logic                valid;
	logic                ready;
	logic [HUE_W-1:0]    base_hue;
	logic [CHROMA_W-1:0] base_chroma;
	logic [HUE_W-1:0]    shifted_hue;

	modport source (output valid, output base_hue, output base_chroma, output shifted_hue,
		input ready);
	modport sink (input valid, input base_hue, input base_chroma, input shifted_hue,
		output ready);

endinterface

// ===== hw/rtl/rhc_prep.sv =====
// ----------------------------------------------------------------------------
// rhc_prep: front stage
// Finds max, min and delta, picks the hue sector, forms the dividend for the
// divider chain and works out the chroma.
// ----------------------------------------------------------------------------
module rhc_prep (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  logic [rhc_pkg::PIXEL_W-1:0] up_pixel,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output rhc_pkg::rhc_div_t         dn_data
);
	import rhc_pkg::*;

	logic [CHAN_W-1:0]   r, g, b;
	logic [CHAN_W-1:0]   lo, d, num;
	logic [HUE_W-1:0]    base;
	logic                neg;
	logic [19:0]         dividend;
	logic [CHROMA_W-1:0] y;
	logic [CHROMA_W-1:0] y_adj;
	logic [CHROMA_W-1:0] chroma;
	logic                valid_s1;
	rhc_div_t            data_s1;
	rhc_div_t            data_d;

	assign r = up_pixel[23:16];
	assign g = up_pixel[15:8];
	assign b = up_pixel[7:0];

	// Sector choice: red wins ties, then green
	always_comb begin
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		priority if (r >= g && r >= b) begin
			d    = r - lo;
			neg  = (g < b);
			num  = neg ? (b - g) : (g - b);
			base = neg ? HUE_FULL : '0;
		end else if (g >= b) begin
			d    = g - lo;
			neg  = (b < r);
			num  = neg ? (r - b) : (b - r);
			base = HUE_GREEN;
		end else begin
			d    = b - lo;
			neg  = (r < g);
			num  = neg ? (g - r) : (r - g);
			base = HUE_BLUE;
		end
	end

	// Dividend 3840*num, written as num*4096 - num*256
	assign dividend = {num, 12'd0} - {4'd0, num, 8'd0};

	// Chroma: 6400*d/255 = 25*d + floor(25*d/255), the last term by reciprocal
	assign y      = {1'b0, d, 4'd0} + {2'b0, d, 3'd0} + {5'd0, d};
	assign y_adj  = y + 13'd1 + {8'd0, y[12:8]};
	assign chroma = y + {8'd0, y_adj[12:8]};

	always_comb begin
		data_d.rem         = dividend[19:12];
		data_d.low         = dividend[11:0];
		data_d.quot        = '0;
		data_d.side.den    = d;
		data_d.side.base   = base;
		data_d.side.neg    = neg;
		data_d.side.grey   = (d == '0);
		data_d.side.chroma = chroma;
	end

	assign up_ready = !valid_s1 || dn_ready;

	// Stage handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= data_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// ===== hw/rtl/rhc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_div_cell: one cell of the divider chain
// Brings down the next dividend bit, trial-subtracts the divisor and shifts
// one quotient bit in, then hands the item to the next cell.
// ----------------------------------------------------------------------------
module rhc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  rhc_pkg::rhc_div_t up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output rhc_pkg::rhc_div_t dn_data
);
	import rhc_pkg::*;

	logic [CHAN_W:0] trial;
	logic [CHAN_W:0] diff;
	logic            take;
	rhc_div_t        next;
	logic            valid_q;
	rhc_div_t        data_q;

	// One restoring division step; the remainder stays below the divisor
	always_comb begin
		trial     = {up_data.rem, up_data.low[QUOT_W-1]};
		diff      = trial - {1'b0, up_data.side.den};
		take      = (trial >= {1'b0, up_data.side.den});
		next      = up_data;
		next.rem  = take ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
		next.low  = {up_data.low[QUOT_W-2:0], 1'b0};
		next.quot = {up_data.quot[QUOT_W-2:0], take};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// ===== hw/rtl/rhc_post.sv =====
// ----------------------------------------------------------------------------
// rhc_post: result stage
// Turns quotient and remainder into floor or ceiling, places the hue in its
// sector, adds the 60 degree turn and holds the result for the sink.
// ----------------------------------------------------------------------------
module rhc_post (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  rhc_pkg::rhc_div_t up_data,
	rhc_result_if.source      res
);
	import rhc_pkg::*;

	logic [HUE_W-1:0]    q_ext;
	logic [HUE_W-1:0]    q_ceil;
	logic [HUE_W-1:0]    hue;
	logic [HUE_W:0]      turned;
	logic [HUE_W-1:0]    shifted;
	logic                valid_q;
	logic [HUE_W-1:0]    hue_q;
	logic [CHROMA_W-1:0] chroma_q;
	logic [HUE_W-1:0]    shifted_q;

	// Negative offsets round away from the sector base, so they take the ceiling
	always_comb begin
		q_ext  = {{(HUE_W-QUOT_W){1'b0}}, up_data.quot};
		q_ceil = q_ext + {{(HUE_W-1){1'b0}}, (up_data.rem != '0)};
		if (up_data.side.grey) begin
			hue = '0;
		end else if (up_data.side.neg) begin
			hue = up_data.side.base - q_ceil;
		end else begin
			hue = up_data.side.base + q_ext;
		end
		turned  = {1'b0, hue} + {1'b0, HUE_SIXTH};
		shifted = (turned >= {1'b0, HUE_FULL}) ? (turned[HUE_W-1:0] - HUE_FULL)
		                                       : turned[HUE_W-1:0];
	end

	assign up_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			hue_q     <= hue;
			chroma_q  <= up_data.side.chroma;
			shifted_q <= shifted;
		end
	end

	assign res.valid       = valid_q;
	assign res.base_hue    = hue_q;
	assign res.base_chroma = chroma_q;
	assign res.shifted_hue = shifted_q;

endmodule

// ===== hw/rtl/rgb_to_hue_chroma_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hue_chroma_core: RGB to hue and chroma converter
// Converts ARGB pixels to HSL hue, chroma and hue turned by 60 degrees.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Item contents
//  pix      in         pixel (ARGB, alpha ignored)
//  res      out        base_hue, base_chroma, shifted_hue
//
// One pixel is taken per cycle while res is not stalled. Each item passes
// fourteen registers: one front stage, twelve divider cells (one quotient bit
// each) and the output register. The front stage loads on the accepting edge.
// Reset clears only the valid flags of the stages. A stall on res holds the
// items in place; each stage accepts while it is empty or its successor
// moves, so bubbles close up under back-pressure.
//
module rgb_to_hue_chroma_core (
	input  logic         clk,
	input  logic         arst_n,
	rhc_pixel_if.sink    pix,
	rhc_result_if.source res
);
	import rhc_pkg::*;

	logic     chain_valid [0:NUM_CELLS];
	logic     chain_ready [0:NUM_CELLS];
	rhc_div_t chain_data  [0:NUM_CELLS];

	// Sector selection and chroma
	rhc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix.valid),
		.up_ready (pix.ready),
		.up_pixel (pix.pixel),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_data  (chain_data[0])
	);

	// Divider chain
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		rhc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_data  (chain_data[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_data  (chain_data[i+1])
		);
	end

	// Hue assembly and output register
	rhc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[NUM_CELLS]),
		.up_ready (chain_ready[NUM_CELLS]),
		.up_data  (chain_data[NUM_CELLS]),
		.res      (res)
	);

endmodule
